// ===== src/first_fit_block_allocator_core_defines.svh =====
// Assertion helpers for the allocator core.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_CORE_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_CORE_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define FFBA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define FFBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FFBA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define FFBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== src/ffba_pkg.sv =====
`timescale 1ns / 1ps
package ffba_pkg;

    localparam int ADDR_W         = 32;
    localparam int REQ_W          = 13;
    localparam int GRANULE_BYTES  = 256;
    localparam int GRANULE_SHIFT  = $clog2(GRANULE_BYTES);
    localparam int NEED_W         = REQ_W - GRANULE_SHIFT;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_SIZE = 2'd1,
        ST_NO_SPACE = 2'd2,
        ST_BAD_FREE = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ASCAN,
        S_FSCAN,
        S_FNEXT,
        S_FLEFT,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_ASCAN,
        OP_FSCAN,
        OP_FNEXT,
        OP_FLEFT
    } t_dp_op;

    typedef struct packed {
        logic   capture;
        t_dp_op op;
        logic   load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic is_free;
        logic req_bad;
        logic scan_end;
        logic hit;
        logic past;
        logic cur_taken;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== src/ffba_req_if.sv =====
`timescale 1ns / 1ps
interface ffba_req_if;
    import ffba_pkg::*;

    logic              valid;
    logic              ready;
    logic              mode;
    logic [REQ_W-1:0]  request_bytes;
    logic [ADDR_W-1:0] free_address;

    modport source (output valid, mode, request_bytes, free_address, input ready);
    modport sink   (input valid, mode, request_bytes, free_address, output ready);
endinterface

// ===== src/ffba_rsp_if.sv =====
`timescale 1ns / 1ps
interface ffba_rsp_if;
    import ffba_pkg::*;

    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] block_address;
    logic [1:0]        status;

    modport source (output valid, block_address, status, input ready);
    modport sink   (input valid, block_address, status, output ready);
endinterface

// ===== src/first_fit_block_allocator_core.sv =====
`timescale 1ns / 1ps
// First-fit granule allocator. One page of NUM_GRANULES granules of 256 bytes is
// kept as a row of back-to-back chunks in a flip-flop table (length and taken
// flag per starting granule). An allocate request (mode 0) takes the first free
// chunk large enough for request_bytes, splits off the tail, and answers with
// region_base plus the chunk's byte offset; a size that is zero or not a granule
// multiple answers bad size, no fit answers no space. A free request (mode 1)
// releases the chunk starting at free_address and merges it with free neighbors
// on both sides; an address that does not start a taken chunk answers bad free
// address and changes nothing. One result per request. The table is read at one
// entry per cycle while the chunk list is walked, k walk steps in all. For an
// allocate, k counts the chunks visited up to the fit, or every chunk plus the
// end-of-page step when nothing fits (up to NUM_GRANULES+1). For a free, k
// counts the chunks visited up to the named address (up to NUM_GRANULES); a
// free that releases a chunk then merges with the right neighbor and the left.
// A request rejected on its size or address skips the walk. Every result waits
// until the output register is free. One request is in flight at a time; a
// finished result waits in the output register while the next request is taken.
// region_base sits at APB byte address 0 and must only be written while the
// block is idle.
module first_fit_block_allocator_core #(
    parameter int NUM_GRANULES = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    ffba_req_if.sink                    i_req,
    ffba_rsp_if.source                  o_rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import ffba_pkg::*;

    // register index within the APB window (byte address / 4)
    localparam logic REG_REGION_BASE = 1'b0;

    logic [ADDR_W-1:0] r_region_base;
    logic              cfg_wr;
    t_dp_cmd           dp_cmd;
    t_dp_sts           dp_sts;

    // APB: zero wait states, write lands on the access phase
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_REGION_BASE);
    assign prdata = (paddr[2] == REG_REGION_BASE) ? r_region_base : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region_base <= '0;
        end else if (cfg_wr) begin
            r_region_base <= pwdata;
        end
    end

    // sequencer: walk, merge and result hand-off
    ffba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    // chunk table, walk pointers and result registers
    ffba_dp #(
        .NUM_GRANULES (NUM_GRANULES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_sts           (dp_sts),
        .i_region_base   (r_region_base),
        .i_mode          (i_req.mode),
        .i_request_bytes (i_req.request_bytes),
        .i_free_address  (i_req.free_address),
        .i_out_ready     (o_rsp.ready),
        .o_out_valid     (o_rsp.valid),
        .o_block_address (o_rsp.block_address),
        .o_status        (o_rsp.status)
    );

endmodule

// ===== src/ffba_ctrl.sv =====
`timescale 1ns / 1ps
module ffba_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ffba_pkg::t_dp_sts i_sts,
    output ffba_pkg::t_dp_cmd o_cmd
);
    import ffba_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_in_ready     = 1'b0;
        o_cmd.capture  = 1'b0;
        o_cmd.op       = OP_NONE;
        o_cmd.load_out = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    if (i_sts.req_bad) begin
                        n_state = S_DONE;
                    end else if (i_sts.is_free) begin
                        n_state = S_FSCAN;
                    end else begin
                        n_state = S_ASCAN;
                    end
                end
            end
            S_ASCAN: begin
                o_cmd.op = OP_ASCAN;
                if (i_sts.scan_end || i_sts.hit) begin
                    n_state = S_DONE;
                end
            end
            S_FSCAN: begin
                o_cmd.op = OP_FSCAN;
                if (i_sts.hit && i_sts.cur_taken) begin
                    n_state = S_FNEXT;
                end else if (i_sts.scan_end || i_sts.past || i_sts.hit) begin
                    n_state = S_DONE;
                end
            end
            S_FNEXT: begin
                o_cmd.op = OP_FNEXT;
                n_state  = S_FLEFT;
            end
            S_FLEFT: begin
                o_cmd.op = OP_FLEFT;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/ffba_dp.sv =====
`timescale 1ns / 1ps
`include "first_fit_block_allocator_core_defines.svh"
module ffba_dp #(
    parameter int NUM_GRANULES = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ffba_pkg::t_dp_cmd           i_cmd,
    output ffba_pkg::t_dp_sts           o_sts,
    input  logic [ffba_pkg::ADDR_W-1:0] i_region_base,
    input  logic                        i_mode,
    input  logic [ffba_pkg::REQ_W-1:0]  i_request_bytes,
    input  logic [ffba_pkg::ADDR_W-1:0] i_free_address,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [ffba_pkg::ADDR_W-1:0] o_block_address,
    output logic [1:0]                  o_status
);
    import ffba_pkg::*;

    localparam int LW = $clog2(NUM_GRANULES + 1);
    localparam int AW = $clog2(NUM_GRANULES);
    localparam int CW = (LW > NEED_W) ? LW : NEED_W;
    localparam int VW = ADDR_W - GRANULE_SHIFT;

    // chunk table: length and taken flag of the chunk starting at each granule
    logic [LW-1:0]     r_len   [NUM_GRANULES];
    logic              r_taken [NUM_GRANULES];

    logic [LW-1:0]     r_idx;
    logic [LW-1:0]     r_prev;
    logic              r_have_prev;
    logic [LW-1:0]     r_v;
    logic [LW-1:0]     r_len_v;
    logic [NEED_W-1:0] r_need;
    logic              r_is_free;
    logic [ADDR_W-1:0] r_res_addr;
    t_status           r_res_status;
    logic              r_out_valid;
    logic [ADDR_W-1:0] r_out_addr;
    t_status           r_out_status;

    logic [ADDR_W-1:0] req_off;
    logic [VW-1:0]     req_v;
    logic              bad_size;
    logic              bad_free;
    logic              in_range;
    logic [LW-1:0]     cur_len;
    logic              cur_taken;
    logic              scan_end;
    logic              match;
    logic              fit;
    logic              hit;
    logic              past;
    logic [LW-1:0]     next_idx;
    logic [LW-1:0]     need_l;
    logic [LW-1:0]     split_idx;
    logic              left_merge;

    // request checks at capture
    assign req_off  = i_free_address - i_region_base;
    assign req_v    = req_off[ADDR_W-1:GRANULE_SHIFT];
    assign bad_size = (i_request_bytes == '0) || (i_request_bytes[GRANULE_SHIFT-1:0] != '0);
    assign bad_free = (req_off[GRANULE_SHIFT-1:0] != '0) || (req_v >= VW'(NUM_GRANULES));

    // single read of the table at r_idx
    assign in_range  = r_idx < LW'(NUM_GRANULES);
    assign cur_len   = in_range ? r_len[r_idx[AW-1:0]] : '0;
    assign cur_taken = in_range ? r_taken[r_idx[AW-1:0]] : 1'b0;
    assign scan_end  = !in_range || (cur_len == '0);
    assign match     = r_idx == r_v;
    assign fit       = !cur_taken && (CW'(r_need) <= CW'(cur_len));
    assign hit       = !scan_end && (r_is_free ? match : fit);
    assign past      = !scan_end && !match && (r_idx > r_v);
    assign next_idx  = r_idx + cur_len;
    assign need_l    = LW'(r_need);
    assign split_idx = r_idx + need_l;
    assign left_merge = r_have_prev && !cur_taken;

    assign o_sts.is_free   = i_mode;
    assign o_sts.req_bad   = i_mode ? bad_free : bad_size;
    assign o_sts.scan_end  = scan_end;
    assign o_sts.hit       = hit;
    assign o_sts.past      = past;
    assign o_sts.cur_taken = cur_taken;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    // table updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_GRANULES; k++) begin
                r_len[k]   <= (k == 0) ? LW'(NUM_GRANULES) : '0;
                r_taken[k] <= 1'b0;
            end
        end else begin
            case (i_cmd.op)
                OP_ASCAN: begin
                    if (hit) begin
                        if (cur_len > need_l) begin
                            r_len[split_idx[AW-1:0]]   <= cur_len - need_l;
                            r_taken[split_idx[AW-1:0]] <= 1'b0;
                        end
                        r_len[r_idx[AW-1:0]]   <= need_l;
                        r_taken[r_idx[AW-1:0]] <= 1'b1;
                    end
                end
                OP_FNEXT: begin
                    r_taken[r_v[AW-1:0]] <= 1'b0;
                    if (!scan_end && !cur_taken) begin
                        r_len[r_idx[AW-1:0]] <= '0;
                    end
                end
                OP_FLEFT: begin
                    if (left_merge) begin
                        r_len[r_idx[AW-1:0]] <= cur_len + r_len_v;
                        r_len[r_v[AW-1:0]]   <= '0;
                    end else begin
                        r_len[r_v[AW-1:0]] <= r_len_v;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // walk pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_prev      <= '0;
            r_have_prev <= 1'b0;
        end else if (i_cmd.capture) begin
            r_idx       <= '0;
            r_prev      <= '0;
            r_have_prev <= 1'b0;
        end else begin
            case (i_cmd.op)
                OP_ASCAN: begin
                    if (!scan_end && !hit) begin
                        r_idx <= next_idx;
                    end
                end
                OP_FSCAN: begin
                    if (hit && cur_taken) begin
                        r_idx <= next_idx;
                    end else if (!scan_end && !hit && !past) begin
                        r_prev      <= r_idx;
                        r_have_prev <= 1'b1;
                        r_idx       <= next_idx;
                    end
                end
                OP_FNEXT: begin
                    r_idx <= r_prev;
                end
                default: begin
                end
            endcase
        end
    end

    // request payload and result
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_is_free    <= i_mode;
            r_need       <= i_request_bytes[REQ_W-1:GRANULE_SHIFT];
            r_v          <= LW'(req_v);
            r_res_addr   <= '0;
            r_res_status <= i_mode ? ST_BAD_FREE : ST_BAD_SIZE;
        end else begin
            case (i_cmd.op)
                OP_ASCAN: begin
                    if (hit) begin
                        r_res_status <= ST_OK;
                        r_res_addr   <= i_region_base + (ADDR_W'(r_idx) << GRANULE_SHIFT);
                    end else if (scan_end) begin
                        r_res_status <= ST_NO_SPACE;
                    end
                end
                OP_FSCAN: begin
                    if (hit && cur_taken) begin
                        r_len_v <= cur_len;
                    end
                end
                OP_FNEXT: begin
                    if (!scan_end && !cur_taken) begin
                        r_len_v <= r_len_v + cur_len;
                    end
                end
                OP_FLEFT: begin
                    r_res_status <= ST_OK;
                end
                default: begin
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_addr   <= r_res_addr;
            r_out_status <= r_res_status;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_block_address = r_out_addr;
    assign o_status        = r_out_status;

    `FFBA_ASSERT_IMPL(a_first_chunk_live, i_clk, i_rst_n, 1'b1, r_len[0] != '0, "chunk at granule zero lost")
    `FFBA_ASSERT_IMPL(a_idx_bound, i_clk, i_rst_n, 1'b1, r_idx <= LW'(NUM_GRANULES), "walk pointer past page")
    `FFBA_ASSERT_IMPL(a_fail_addr_zero, i_clk, i_rst_n, r_out_valid && (r_out_status != ST_OK), r_out_addr == '0, "failed request carries an address")
    `FFBA_ASSERT_NEXT(a_fit_ok, i_clk, i_rst_n, (i_cmd.op == OP_ASCAN) && hit, r_res_status == ST_OK, "fit not reported as ok")

endmodule
